[rtl/core/lis_pkg.sv]
`default_nettype none

package lis_pkg;

    localparam int MAX_LEN = 1024;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int VAL_W   = 32;
    localparam int RUN_W   = 11;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] key;
        logic                    last;
        logic                    done;
        logic                    appended;
    } lis_token_t;

endpackage

`default_nettype wire

[rtl/core/longest_increasing_subsequence_length.sv]
// Longest strictly increasing subsequence length of a stream of signed words.
// Input channel: item_valid / item_stall with value and last; one word per item.
// Output channel: result_valid / result_stall with run_length, overflow, is_last;
// exactly one result word per input word, in order.
// A word enters a chain of MAX_LEN cells (1024), one cell per tail of the
// patience-sorting store, moving one cell per cycle while the chain advances.
// It settles in the first cell that is empty or holds a tail not below it;
// the last word of a sequence empties each cell as it passes. Each word passes
// every cell register and the tally's output register; the chain length sets
// the latency. Words are taken one per cycle while the chain is not frozen.
// When result_stall holds a waiting result, the whole chain freezes and
// item_stall is raised in the same cycle; nothing is lost or repeated.
// Reset empties every cell and clears the length and overflow state; no
// clearing pass is needed, and words are taken right after reset.
`default_nettype none

module longest_increasing_subsequence_length (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [lis_pkg::VAL_W-1:0] value,
    input  logic                          last,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [lis_pkg::RUN_W-1:0]     run_length,
    output logic                          overflow,
    output logic                          is_last
);
    import lis_pkg::*;

    lis_token_t chain [0:MAX_LEN];
    logic       advance;

    assign item_stall = !advance;

    always_comb
    begin
        chain[0].valid    = item_valid;
        chain[0].key      = value;
        chain[0].last     = last;
        chain[0].done     = 1'b0;
        chain[0].appended = 1'b0;
    end

    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        lis_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    lis_tally u_tally (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_in       (chain[MAX_LEN]),
        .result_stall (result_stall),
        .advance      (advance),
        .result_valid (result_valid),
        .run_length   (run_length),
        .overflow     (overflow),
        .is_last      (is_last)
    );

endmodule

`default_nettype wire

[rtl/core/lis_cell.sv]
`default_nettype none

module lis_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  lis_pkg::lis_token_t tok_in,
    output lis_pkg::lis_token_t tok_out
);
    import lis_pkg::*;

    logic                    occ_reg;
    logic                    occ_next;
    logic signed [VAL_W-1:0] tail_reg;
    logic signed [VAL_W-1:0] tail_next;
    lis_token_t              tok_reg;
    lis_token_t              tok_next;
    logic                    land;

    // word settles here if the cell is empty or its tail is not below the key
    always_comb
    begin
        land               = tok_in.valid && !tok_in.done &&
                             (!occ_reg || !(tail_reg < tok_in.key));
        tail_next          = land ? tok_in.key : tail_reg;
        occ_next           = (tok_in.valid && tok_in.last) ? 1'b0 : (occ_reg | land);
        tok_next           = tok_in;
        tok_next.done      = tok_in.done | land;
        tok_next.appended  = tok_in.appended | (land & !occ_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= 1'b0;
            tok_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            occ_reg <= occ_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tail_reg <= tail_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

[rtl/core/lis_tally.sv]
`default_nettype none

module lis_tally (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lis_pkg::lis_token_t    tok_in,
    input  logic                   result_stall,
    output logic                   advance,
    output logic                   result_valid,
    output logic [lis_pkg::RUN_W-1:0] run_length,
    output logic                   overflow,
    output logic                   is_last
);
    import lis_pkg::*;

    logic             tok_valid;
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             valid_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             out_ovf_reg;
    logic             out_last_reg;

    assign tok_valid = tok_in.valid;

    assign advance = !valid_reg || !result_stall;

    // a word that never settled fell off the end of a full chain
    always_comb
    begin
        count_next = count_reg + LEN_W'(tok_in.appended);
        ovf_next   = ovf_reg | !tok_in.done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= tok_valid;
            if (tok_valid)
            begin
                if (tok_in.last)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    count_reg <= count_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tok_valid)
        begin
            out_len_reg  <= count_next;
            out_ovf_reg  <= ovf_next;
            out_last_reg <= tok_in.last;
        end
    end

    assign result_valid = valid_reg;
    assign run_length   = RUN_W'(out_len_reg);
    assign overflow     = out_ovf_reg;
    assign is_last      = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LEN_W'(MAX_LEN))
        else $error("length count beyond store size");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_ovf_reg |-> out_len_reg == LEN_W'(MAX_LEN))
        else $error("overflow reported with store not full");

    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && tok_in.valid && tok_in.last |=> count_reg == '0 && !ovf_reg)
        else $error("state not cleared after last word");

endmodule

`default_nettype wire

[test/lis_checker.sv]
`timescale 1ns / 100ps

module lis_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  logic                             item_stall,
    input  logic signed [lis_pkg::VAL_W-1:0] value,
    input  logic                             last,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  logic [lis_pkg::RUN_W-1:0]        run_length,
    input  logic                             overflow,
    input  logic                             is_last,
    output int                               mismatches,
    output int                               pending
);
    import lis_pkg::*;

    typedef struct packed {
        logic [RUN_W-1:0] run_length;
        logic             overflow;
        logic             is_last;
    } run_result_t;

    // tails[k]: smallest tail of a strictly increasing run of length k+1
    logic signed [VAL_W-1:0] tails [MAX_LEN];
    int                      tail_count;
    logic                    overflow_seen;
    run_result_t             run_results_due[$];

    function automatic run_result_t next_run_result(input logic signed [VAL_W-1:0] v,
                                                    input logic l);
        int          lo;
        int          hi;
        int          mid;
        run_result_t r;
        if (tail_count == 0 || v > tails[tail_count - 1])
        begin
            if (tail_count < MAX_LEN)
            begin
                tails[tail_count] = v;
                tail_count++;
            end
            else
            begin
                overflow_seen = 1'b1;
            end
        end
        else
        begin
            lo = 0;
            hi = tail_count;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (tails[mid] < v)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo < tail_count)
                tails[lo] = v;
        end
        r.run_length = RUN_W'(tail_count);
        r.overflow   = overflow_seen;
        r.is_last    = l;
        if (l)
        begin
            tail_count    = 0;
            overflow_seen = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        run_result_t want;
        if (!rst_n)
        begin
            run_results_due.delete();
            tail_count    = 0;
            overflow_seen = 1'b0;
            mismatches    = 0;
            pending       = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (run_results_due.size() == 0)
                begin
                    $error("result word with nothing expected: run_length %0d", run_length);
                    mismatches++;
                end
                else
                begin
                    want = run_results_due.pop_front();
                    if (run_length !== want.run_length)
                    begin
                        $error("run_length: expected %0d, actual %0d",
                               want.run_length, run_length);
                        mismatches++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, actual %0b", want.overflow, overflow);
                        mismatches++;
                    end
                    if (is_last !== want.is_last)
                    begin
                        $error("is_last: expected %0b, actual %0b", want.is_last, is_last);
                        mismatches++;
                    end
                end
            end
            if (item_valid && !item_stall)
                run_results_due = {run_results_due, next_run_result(value, last)};
            pending = run_results_due.size();
        end
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import lis_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 2000;
    localparam int DRAIN_CYCLES = MAX_LEN + 64;
    localparam int RANDOM_WORDS = 400;
    localparam int CALM_WORDS   = 100;
    localparam int HOLD_WORDS   = 34;

    logic                    clk;
    logic                    rst_n        = 1'b0;
    logic                    item_valid   = 1'b0;
    logic                    item_stall;
    logic signed [VAL_W-1:0] value        = '0;
    logic                    last         = 1'b0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic [RUN_W-1:0]        run_length;
    logic                    overflow;
    logic                    is_last;
    int                      mismatches;
    int                      pending;

    bit tx_idle  = 1'b1;
    bit rx_idle  = 1'b1;
    bit hold_req = 1'b0;
    int words_sent;
    int seq_count;
    int cycle_count;

    longest_increasing_subsequence_length u_dut (.*);

    lis_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d words still expected", cycle_count, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random stall bursts, plus one long hold-off on request
    initial
    begin : rx_side
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 16);
                result_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input logic signed [VAL_W-1:0] v, input logic l);
        int gap;
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        last       <= l;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
        if (l)
            seq_count++;
    endtask

    task automatic send_random_sequence(input int len);
        int                      kind;
        logic signed [VAL_W-1:0] base;
        logic signed [VAL_W-1:0] v;
        kind = $urandom_range(0, 3);
        base = $urandom;
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                0: v = $urandom;
                1: v = 32'($urandom_range(0, 15)) - 8;
                2: v = base + 32'(i * 4) - 32'($urandom_range(0, 6));
                default:
                begin
                    base = base - 32'($urandom_range(0, 2));
                    v    = base;
                end
            endcase
            send_word(v, i == len - 1);
        end
    endtask

    initial
    begin : stimulus
        int rand_words;
        int len;
        words_sent = 0;
        seq_count  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-word sequence at the most negative value
        send_word(32'sh8000_0000, 1'b1);
        // extremes, equal values, replacement at the low end
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh0000_0000, 1'b0);
        send_word(32'sh0000_0000, 1'b0);
        send_word(32'shFFFF_FFFF, 1'b0);
        send_word(32'sd5, 1'b0);
        send_word(32'sd5, 1'b0);
        send_word(32'sd7, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b1);
        // falling with a repeat
        send_word(32'sd10, 1'b0);
        send_word(32'sd9, 1'b0);
        send_word(32'sd8, 1'b0);
        send_word(32'sd8, 1'b0);
        send_word(32'sd1, 1'b1);
        // rising, then a value that replaces inside the store
        send_word(32'sd1, 1'b0);
        send_word(32'sd2, 1'b0);
        send_word(32'sd3, 1'b0);
        send_word(32'sd4, 1'b0);
        send_word(32'sd2, 1'b1);

        // long output hold-off: once a result waits, the chain freezes and input stalls
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 4; i++)
            send_word(32'(i * 5) - 2000, 1'b0);
        item_valid <= 1'b0;
        while (!result_valid)
            @(posedge clk);
        for (int i = 4; i < HOLD_WORDS; i++)
            send_word(32'(i * 5) - 2000, i == HOLD_WORDS - 1);
        tx_idle = 1'b1;

        rand_words = 0;
        while (rand_words < RANDOM_WORDS)
        begin
            if (rand_words >= RANDOM_WORDS - CALM_WORDS)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            len = $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0)
                len = 1;
            send_random_sequence(len);
            rand_words += len;
        end
        item_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d words in %0d sequences: extremes, repeats, replacements,",
                 words_sent, seq_count);
        $display("and a %0d-cycle output hold-off with the input held back",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
